/* hw/rtl/fis_pkg.sv */
// Package: float formats, constants and per-stage arithmetic for the reciprocal square root pipe.
package fis_pkg;

  localparam logic [31:0] MAGIC_BITS    = 32'h5F3759DF;
  localparam logic [31:0] HALF_BITS     = 32'h3F000000;
  localparam logic [31:0] ONE_HALF_BITS = 32'h3FC00000;
  localparam logic [31:0] QNAN_BITS     = 32'h7FC00000;
  localparam int unsigned WW            = 50;

  typedef enum logic [1:0] {
    CLS_NUM,
    CLS_ZERO,
    CLS_INF,
    CLS_NAN
  } cls_e;

  // Unrounded value: w / 2^49 * 2^(t - 127); leading one at bit 49 once normalized.
  typedef struct packed {
    logic               sgn;
    cls_e               cls;
    logic signed [10:0] t;
    logic [5:0]         lz;
    logic [WW-1:0]      w;
  } norm_t;

  // Aligned operands of an add, ahead of the wide add or subtract.
  typedef struct packed {
    logic               sgn;
    logic               sub;
    cls_e               cls;
    logic signed [10:0] t;
    logic [WW-1:0]      wb;
    logic [WW-1:0]      ws;
  } addp_t;

  function automatic logic [31:0] rsqrt_seed(input logic [31:0] x);
    return MAGIC_BITS - {x[31], x[31:1]};
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic [7:0] eff_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  endfunction

  function automatic logic [23:0] eff_mant(input logic [31:0] a);
    return {(a[30:23] != 8'd0), a[22:0]};
  endfunction

  // Multiply front end: unpack and form the full mantissa product.
  function automatic norm_t mul_a(input logic [31:0] a, input logic [31:0] b);
    norm_t       r;
    logic [47:0] p;
    p      = 48'(eff_mant(a)) * 48'(eff_mant(b));
    r.sgn  = a[31] ^ b[31];
    r.lz   = 6'd0;
    r.w    = {p, 2'b00};
    r.t    = $signed({3'b000, eff_exp(a)}) + $signed({3'b000, eff_exp(b)}) - 11'sd126;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && (b[30:0] == 31'd0)) ||
        (is_inf(b) && (a[30:0] == 31'd0))) begin
      r.cls = CLS_NAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r.cls = CLS_INF;
    end else if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
      r.cls = CLS_ZERO;
    end else begin
      r.cls = CLS_NUM;
    end
    return r;
  endfunction

  // Add front end: order by magnitude, align the smaller operand with sticky.
  function automatic addp_t add_a(input logic [31:0] a, input logic [31:0] b);
    addp_t         r;
    logic          a_big;
    logic [31:0]   bg;
    logic [31:0]   sm;
    logic [7:0]    d;
    logic [WW-1:0] wsf;
    a_big = (a[30:0] >= b[30:0]);
    bg    = a_big ? a : b;
    sm    = a_big ? b : a;
    d     = eff_exp(bg) - eff_exp(sm);
    wsf   = {1'b0, eff_mant(sm), 25'd0};
    r.wb  = {1'b0, eff_mant(bg), 25'd0};
    if (d >= 8'd50) begin
      r.ws = {{(WW-1){1'b0}}, |eff_mant(sm)};
    end else begin
      r.ws = (wsf >> d) | {{(WW-1){1'b0}}, |(wsf & ((50'd1 << d) - 50'd1))};
    end
    r.t   = $signed({3'b000, eff_exp(bg)}) + 11'sd1;
    r.sgn = bg[31];
    r.sub = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
      r.cls = CLS_NAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r.cls = CLS_INF;
      r.sgn = is_inf(a) ? a[31] : b[31];
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r.cls = CLS_ZERO;
      r.sgn = a[31] & b[31];
    end else begin
      r.cls = CLS_NUM;
    end
    return r;
  endfunction

  function automatic norm_t add_b(input addp_t p);
    norm_t r;
    r.sgn = p.sgn;
    r.cls = p.cls;
    r.t   = p.t;
    r.lz  = 6'd0;
    r.w   = p.sub ? (p.wb - p.ws) : (p.wb + p.ws);
    // An exact cancellation rounds to plus zero.
    if ((p.cls == CLS_NUM) && (r.w == '0)) begin
      r.cls = CLS_ZERO;
      r.sgn = 1'b0;
    end
    return r;
  endfunction

  function automatic norm_t nrm_lzc(input norm_t n);
    norm_t r;
    r    = n;
    r.lz = 6'd0;
    for (int i = 0; i < WW; i++) begin
      if (n.w[i]) r.lz = 6'(WW - 1 - i);
    end
    return r;
  endfunction

  function automatic norm_t nrm_shift(input norm_t n);
    norm_t r;
    r    = n;
    r.w  = n.w << n.lz;
    r.t  = n.t - $signed({5'b00000, n.lz});
    r.lz = 6'd0;
    return r;
  endfunction

  // Round to nearest even; subnormal results take a right shift with sticky.
  function automatic logic [31:0] nrm_round(input norm_t n);
    logic [31:0]   res;
    logic [WW-1:0] m;
    logic          stk;
    logic [10:0]   sh;
    logic [7:0]    e;
    logic          rnd;
    logic [30:0]   pk;
    m   = n.w;
    stk = 1'b0;
    e   = n.t[7:0];
    sh  = 11'(11'sd1 - n.t);
    if (n.t < 11'sd1) begin
      e = 8'd0;
      if (sh >= 11'd50) begin
        m   = '0;
        stk = |n.w;
      end else begin
        m   = n.w >> sh;
        stk = |(n.w & ((50'd1 << sh) - 50'd1));
      end
    end
    rnd = m[25] & (m[26] | stk | (|m[24:0]));
    pk  = {e, m[48:26]} + 31'(rnd);
    case (n.cls)
      CLS_NAN:  res = QNAN_BITS;
      CLS_INF:  res = {n.sgn, 8'hFF, 23'd0};
      CLS_ZERO: res = {n.sgn, 31'd0};
      default: begin
        if (n.t >= 11'sd255) res = {n.sgn, 8'hFF, 23'd0};
        else                 res = {n.sgn, pk};
      end
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/fast_inverse_sqrt_core.sv */
// Top level: pipelined fast reciprocal square root with one Newton step.
// Throughput: one beat per cycle; every stage advances together whenever the output
// register is empty or being drained, so a stall freezes the whole pipe.
// Reset: rst_ni clears all stage valid bits asynchronously; data registers are not reset.
// Stages: seed + 0.5*x (4), *y (4), *y (4), 1.5 - p (5), y * corr (4).
module fast_inverse_sqrt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] result_bits
);

  localparam int unsigned NS = 21;

  logic                   adv;
  logic [NS:1]            vld_q;
  logic [31:0]            est_q [1:NS];
  fis_pkg::norm_t         nrm_q [1:NS];
  logic [31:0]            fb_q  [1:NS];
  fis_pkg::addp_t         add_q;

  // Advance the whole pipe unless the final result is held by the consumer.
  assign adv             = !vld_q[NS] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NS];
  assign m_axis_tdata_o  = fb_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-1:1], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Carry the bit-trick seed alongside every stage.
      est_q[1] <= fis_pkg::rsqrt_seed(s_axis_tdata_i);
      for (int k = 2; k <= NS; k++) begin
        est_q[k] <= est_q[k-1];
      end
      // half_x = x * 0.5
      nrm_q[1]  <= fis_pkg::mul_a(s_axis_tdata_i, fis_pkg::HALF_BITS);
      nrm_q[2]  <= fis_pkg::nrm_lzc(nrm_q[1]);
      nrm_q[3]  <= fis_pkg::nrm_shift(nrm_q[2]);
      fb_q[4]   <= fis_pkg::nrm_round(nrm_q[3]);
      // p1 = half_x * y
      nrm_q[5]  <= fis_pkg::mul_a(fb_q[4], est_q[4]);
      nrm_q[6]  <= fis_pkg::nrm_lzc(nrm_q[5]);
      nrm_q[7]  <= fis_pkg::nrm_shift(nrm_q[6]);
      fb_q[8]   <= fis_pkg::nrm_round(nrm_q[7]);
      // p2 = p1 * y
      nrm_q[9]  <= fis_pkg::mul_a(fb_q[8], est_q[8]);
      nrm_q[10] <= fis_pkg::nrm_lzc(nrm_q[9]);
      nrm_q[11] <= fis_pkg::nrm_shift(nrm_q[10]);
      fb_q[12]  <= fis_pkg::nrm_round(nrm_q[11]);
      // corr = 1.5 - p2, as 1.5 + (-p2)
      add_q     <= fis_pkg::add_a(fis_pkg::ONE_HALF_BITS, {~fb_q[12][31], fb_q[12][30:0]});
      nrm_q[14] <= fis_pkg::add_b(add_q);
      nrm_q[15] <= fis_pkg::nrm_lzc(nrm_q[14]);
      nrm_q[16] <= fis_pkg::nrm_shift(nrm_q[15]);
      fb_q[17]  <= fis_pkg::nrm_round(nrm_q[16]);
      // result = y * corr
      nrm_q[18] <= fis_pkg::mul_a(est_q[17], fb_q[17]);
      nrm_q[19] <= fis_pkg::nrm_lzc(nrm_q[18]);
      nrm_q[20] <= fis_pkg::nrm_shift(nrm_q[19]);
      fb_q[21]  <= fis_pkg::nrm_round(nrm_q[20]);
    end
  end

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[1])
    else $error("accepted beat did not enter the first stage");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS] && !m_axis_tready_i |=> vld_q[NS] && $stable(fb_q[NS]))
    else $error("stalled result was lost or changed");

  a_nan_canon : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && fis_pkg::is_nan(m_axis_tdata_o) |-> m_axis_tdata_o == fis_pkg::QNAN_BITS)
    else $error("non-canonical NaN on output");

  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NS] |-> s_axis_tready_o)
    else $error("input stalled with an empty output stage");

endmodule

/* dv/fast_inverse_sqrt_core_tb.sv */
// Testbench: checks the reciprocal square root pipe against a bit-exact soft-float predictor.
module fast_inverse_sqrt_core_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;    // longer than the pipe latency

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;             // [31:0] value_bits
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;                  // [31:0] result_bits

  logic [31:0] rsqrt_q[$];       // expected result_bits, oldest first
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned sink_hold = 0;    // cycles the receiver still holds off
  logic        src_idle_en = 1'b0;
  logic        sink_idle_en = 1'b0;

  fast_inverse_sqrt_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Soft-float predictor, single precision, round to nearest even, subnormals kept.
  // ---------------------------------------------------------------------------
  function automatic logic fp_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  // Significand and exponent such that |a| = sig * 2^xp.
  function automatic void fp_split(input logic [31:0] a, output logic [23:0] sig,
                                   output int xp);
    if (a[30:23] == 8'd0) begin
      sig = {1'b0, a[22:0]};
      xp  = -126 - 23;
    end else begin
      sig = {1'b1, a[22:0]};
      xp  = int'(a[30:23]) - 127 - 23;
    end
  endfunction

  // Round s * m * 2^xp (m nonzero) to a single-precision pattern.
  function automatic logic [31:0] fp_round(input logic s, input int xp, input logic [63:0] m);
    int          lead;
    int          bexp;
    int          sh;
    logic [63:0] mm;
    logic        stk;
    logic        rnd;
    logic [31:0] pk;
    lead = 0;
    for (int i = 0; i < 64; i++) if (m[i]) lead = i;
    mm   = m << (63 - lead);
    bexp = xp + lead + 127;
    stk  = 1'b0;
    if (bexp < 1) begin
      sh = 1 - bexp;
      if (sh >= 64) begin
        stk = |mm;
        mm  = '0;
      end else begin
        stk = |(mm & ((64'd1 << sh) - 64'd1));
        mm  = mm >> sh;
      end
      bexp = 0;
    end
    if (bexp >= 255) return {s, 8'hFF, 23'd0};
    rnd = mm[39] & (mm[40] | stk | (|mm[38:0]));
    pk  = {1'b0, bexp[7:0], mm[62:40]} + {31'd0, rnd};
    return {s, pk[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [23:0] sa, sb;
    int          xa, xb;
    s = a[31] ^ b[31];
    if (fp_nan(a) || fp_nan(b)) return fis_pkg::QNAN_BITS;
    if ((fp_inf(a) && b[30:0] == 31'd0) || (fp_inf(b) && a[30:0] == 31'd0)) begin
      return fis_pkg::QNAN_BITS;
    end
    if (fp_inf(a) || fp_inf(b)) return {s, 8'hFF, 23'd0};
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
    fp_split(a, sa, xa);
    fp_split(b, sb, xb);
    return fp_round(s, xa + xb, 64'(sa) * 64'(sb));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] bg, sm;
    logic [23:0] sgb, sgs;
    int          xb, xs, d;
    logic [63:0] mb, ms, full, r;
    if (fp_nan(a) || fp_nan(b)) return fis_pkg::QNAN_BITS;
    if (fp_inf(a) && fp_inf(b)) return (a[31] != b[31]) ? fis_pkg::QNAN_BITS : a;
    if (fp_inf(a)) return a;
    if (fp_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    bg = (a[30:0] >= b[30:0]) ? a : b;
    sm = (a[30:0] >= b[30:0]) ? b : a;
    fp_split(bg, sgb, xb);
    fp_split(sm, sgs, xs);
    d    = xb - xs;
    mb   = 64'(sgb) << 38;
    full = 64'(sgs) << 38;
    // Keep shifted-out bits as a sticky bit in the lsb.
    if (d >= 62) ms = {63'd0, |full};
    else         ms = (full >> d) | {63'd0, |(full & ((64'd1 << d) - 64'd1))};
    r = (a[31] ^ b[31]) ? (mb - ms) : (mb + ms);
    if (r == '0) return 32'd0;  // exact cancellation gives plus zero
    return fp_round(bg[31], xb - 38, r);
  endfunction

  function automatic logic [31:0] rsqrt_expected(input logic [31:0] x);
    logic [31:0] y, hx, p1, p2, corr, res;
    y    = fis_pkg::MAGIC_BITS - {x[31], x[31:1]};
    hx   = fp_mul(x, fis_pkg::HALF_BITS);
    p1   = fp_mul(hx, y);
    p2   = fp_mul(p1, y);
    corr = fp_add(fis_pkg::ONE_HALF_BITS, {~p2[31], p2[30:0]});
    res  = fp_mul(y, corr);
    return fp_nan(res) ? fis_pkg::QNAN_BITS : res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one beat per call, with random gaps when enabled.
  // ---------------------------------------------------------------------------
  task automatic send_value(input logic [31:0] v);
    while (src_idle_en && $urandom_range(99) < 19) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rsqrt_q.push_back(rsqrt_expected(v));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (rsqrt_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver ready: hold off during a pressure stretch, else stall at random when enabled.
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold       <= sink_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= sink_idle_en ? ($urandom_range(99) >= 19) : 1'b1;
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (rsqrt_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata_o);
        fail_cnt++;
      end else if (rsqrt_q[0] !== m_axis_tdata_o) begin
        $display("%0t: result_bits mismatch: expected %h actual %h",
                 $time, rsqrt_q[0], m_axis_tdata_o);
        fail_cnt++;
        void'(rsqrt_q.pop_front());
      end else begin
        void'(rsqrt_q.pop_front());
      end
    end
  end

  // Watchdog: end the run with a failure once the total cycle count passes CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("fast_inverse_sqrt_core_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Zeros, infinities, NaNs, subnormal and normal limits, negatives.
  task automatic test_special_values();
    logic [31:0] vals[$];
    vals = {32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
            32'h7F800001, 32'hFFC00001, 32'h00000001, 32'h00000002, 32'h007FFFFF,
            32'h00800000, 32'h7F7FFFFF, 32'h3F800000, 32'h40800000, 32'h3E800000,
            32'hBF800000, 32'hFFFFFFFF, 32'h80000001, 32'h5F3759DF, 32'h3F000000,
            32'h807FFFFF, 32'hFF7FFFFF, 32'h55555555, 32'hAAAAAAAA};
    foreach (vals[i]) send_value(vals[i]);
    stop_sending();
    wait_drained();
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned k;
    k = $urandom_range(9);
    case (k)
      0, 1, 2: return $urandom();                                            // any pattern
      3:       return {$urandom_range(1) == 0, 8'd0, 23'($urandom())};       // subnormal
      4:       return {$urandom_range(3) == 0, 8'hFF, 23'($urandom_range(1) ? $urandom() : 0)};
      default: return {1'b0, 8'($urandom_range(200, 40)), 23'($urandom())};  // common positives
    endcase
  endfunction

  // Random traffic: first a stretch with no idling on either side, then random stalls.
  task automatic test_random_stream(input int unsigned n);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 3) begin
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
      end
      send_value(pick_value());
    end
    stop_sending();
    wait_drained();
  endtask

  // Hold the receiver off long enough that the pipe fills and stalls its input.
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    sink_hold   = 150;
    for (int i = 0; i < 80; i++) send_value(pick_value());
    stop_sending();
    wait_drained();
    src_idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_special_values();
    test_backpressure();
    test_random_stream(950);
    if (fail_cnt == 0) begin
      $display("fast_inverse_sqrt_core_tb: PASS");
    end else begin
      $display("fast_inverse_sqrt_core_tb: FAIL");
    end
    $finish;
  end

endmodule
